### sv/ppip_pkg.sv
// Shared types, constants and helpers for the projected point-in-polygon block.
package ppip_pkg;

   localparam int NORM_W = 18;

   typedef enum logic {
      OP_START  = 1'b0,
      OP_VERTEX = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // control that travels with each transaction down the pipe
   typedef struct packed {
      logic start;
      logic last;
      logic too_few;
   } ctrl_type;

   function automatic logic [NORM_W-1:0] norm_mag(input logic [NORM_W-1:0] n);
      logic [NORM_W-1:0] r;
      r = n[NORM_W-1] ? NORM_W'(~n + 1'b1) : n;
      return r;
   endfunction

endpackage

### sv/projected_point_in_polygon_top.sv
// Top level: stream ports, pipeline control, parity accumulation and result register.
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+-------------------------------------------
//   req      | in  | req_tvalid/req_tready | tdata coords+normals, tuser opcode, tlast
//   rsp      | out | rsp_tvalid/rsp_tready | tdata inside_res, too_few_vertices
//
// One transaction per cycle while req_tready is high. The closing transaction passes through
// the operand registers, the product registers (two lanes, each with two (CW+1)-bit
// multipliers), then the result register, which raises rsp_tvalid.
// Synchronous active-high reset clears query point, axis, tally, parity and valids.
// A stall on rsp holds the pipe only when a transaction that ends a polygon sits in the
// product registers while the result register is still full.
module projected_point_in_polygon_top import ppip_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // coord_x, coord_y, coord_z, normal_x, normal_y, normal_z, zero fill
   input  logic [((3*COORD_WIDTH+3*NORM_W+7)/8)*8-1:0] req_tdata,
   // opcode
   input  logic                 req_tuser,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // inside_res, too_few_vertices, zero fill
   output logic [7:0]           rsp_tdata
);

   localparam int CW    = COORD_WIDTH;
   localparam int OFS_Y = CW;
   localparam int OFS_Z = 2 * CW;
   localparam int OFS_NX = 3 * CW;
   localparam int OFS_NY = OFS_NX + NORM_W;
   localparam int OFS_NZ = OFS_NY + NORM_W;

   logic                 en1, en2, out_free, accept, s2_fire;
   logic                 v1_ff, v1_in, v2_ff, v2_in;
   logic                 parity_ff, parity_in, par_new;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 inside_ff, inside_in, too_few_ff, too_few_in;
   ctrl_type             ctrl1_ff, ctrl2_ff;
   logic [1:0][CW:0]     a1_ff, b1_ff, c1_ff, d1_ff;
   logic [1:0]           str1_ff, lane_hit;
   opcode_type           opcode;

   assign opcode = opcode_type'(req_tuser);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign en2        = !v2_ff || !ctrl2_ff.last || out_free;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;
   assign accept     = req_tvalid && req_tready;
   assign s2_fire    = v2_ff && en2;

   ppip_front #(.CW(CW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .s1_load   (en1),
      .opcode    (opcode),
      .last      (req_tlast),
      .coord_x   ($signed(req_tdata[CW-1:0])),
      .coord_y   ($signed(req_tdata[OFS_Y+CW-1:OFS_Y])),
      .coord_z   ($signed(req_tdata[OFS_Z+CW-1:OFS_Z])),
      .normal_x  (req_tdata[OFS_NX+NORM_W-1:OFS_NX]),
      .normal_y  (req_tdata[OFS_NY+NORM_W-1:OFS_NY]),
      .normal_z  (req_tdata[OFS_NZ+NORM_W-1:OFS_NZ]),
      .ctrl1_ff  (ctrl1_ff),
      .a1_ff     (a1_ff),
      .b1_ff     (b1_ff),
      .c1_ff     (c1_ff),
      .d1_ff     (d1_ff),
      .str1_ff   (str1_ff)
   );

   for (genvar g = 0; g < 2; g++) begin : g_lane
      ppip_cross #(.CW(CW)) u_cross (
         .clock    (clock),
         .load     (en2),
         .a        (a1_ff[g]),
         .b        (b1_ff[g]),
         .c        (c1_ff[g]),
         .d        (d1_ff[g]),
         .straddle (str1_ff[g]),
         .crosses  (lane_hit[g])
      );
   end

   assign par_new = parity_ff ^ lane_hit[0] ^ lane_hit[1];

   always_comb begin
      v1_in        = en1 ? accept : v1_ff;
      v2_in        = en2 ? v1_ff : v2_ff;
      parity_in    = parity_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      inside_in    = inside_ff;
      too_few_in   = too_few_ff;
      if (s2_fire) begin
         parity_in = (ctrl2_ff.start || ctrl2_ff.last) ? 1'b0 : par_new;
         if (ctrl2_ff.last) begin
            rsp_valid_in = 1'b1;
            too_few_in   = ctrl2_ff.too_few;
            inside_in    = !ctrl2_ff.too_few && par_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         parity_ff    <= parity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         ctrl2_ff <= ctrl1_ff;
      end
      inside_ff  <= inside_in;
      too_few_ff <= too_few_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, too_few_ff, inside_ff};

`ifndef NO_ASSERTIONS
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(v2_ff && ctrl2_ff.last))
      else $error("result raised without a closing transaction");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(inside_ff && too_few_ff))
      else $error("inside flagged on a degenerate polygon");

   a_empty_polygon: assert property (@(posedge clock) disable iff (reset)
      (s2_fire && ctrl2_ff.start && ctrl2_ff.last) |=> (rsp_valid_ff && too_few_ff))
      else $error("empty polygon did not report too few vertices");

   a_full_pipe_blocks: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !en2) |-> !req_tready)
      else $error("input taken while stage one is blocked");
`endif

endmodule

### sv/ppip_front.sv
// Input stage: axis pick, projection, polygon state and edge operand registers.
module ppip_front import ppip_pkg::*; #(
   parameter int CW = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_accept,
   input  logic                      s1_load,
   input  opcode_type                opcode,
   input  logic                      last,
   input  logic signed [CW-1:0]      coord_x,
   input  logic signed [CW-1:0]      coord_y,
   input  logic signed [CW-1:0]      coord_z,
   input  logic [NORM_W-1:0]         normal_x,
   input  logic [NORM_W-1:0]         normal_y,
   input  logic [NORM_W-1:0]         normal_z,
   output ctrl_type                  ctrl1_ff,
   output logic [1:0][CW:0]          a1_ff,
   output logic [1:0][CW:0]          b1_ff,
   output logic [1:0][CW:0]          c1_ff,
   output logic [1:0][CW:0]          d1_ff,
   output logic [1:0]                str1_ff
);

   localparam logic [1:0] TALLY_FULL = 2'd3;

   logic signed [CW-1:0] query_u_ff, query_v_ff, query_u_in, query_v_in;
   logic signed [CW-1:0] first_u_ff, first_v_ff, prev_u_ff, prev_v_ff;
   axis_type             axis_ff, axis_in, new_axis, axis_sel;
   logic [1:0]           tally_ff, tally_in, tally_inc;

   logic [NORM_W-1:0]    mx, my, mz;
   logic signed [CW-1:0] u, v;
   logic                 is_start;

   logic signed [CW-1:0] pu [2];
   logic signed [CW-1:0] pv [2];
   logic signed [CW-1:0] cu [2];
   logic signed [CW-1:0] cv [2];
   logic [1:0]           edge_en;
   logic [1:0][CW:0]     a1_in, b1_in, c1_in, d1_in;
   logic [1:0]           str1_in;
   ctrl_type             ctrl1_in;

   assign is_start = (opcode == OP_START);
   assign mx = norm_mag(normal_x);
   assign my = norm_mag(normal_y);
   assign mz = norm_mag(normal_z);

   // ties favor X, then Y
   always_comb begin
      if (mx >= my && mx >= mz) begin
         new_axis = AXIS_X;
      end else if (my >= mz) begin
         new_axis = AXIS_Y;
      end else begin
         new_axis = AXIS_Z;
      end
   end

   assign axis_sel = is_start ? new_axis : axis_ff;

   always_comb begin
      case (axis_sel)
         AXIS_X: begin
            u = coord_y;
            v = coord_z;
         end
         AXIS_Y: begin
            u = coord_x;
            v = coord_z;
         end
         default: begin
            u = coord_x;
            v = coord_y;
         end
      endcase
   end

   assign tally_inc = (tally_ff == TALLY_FULL) ? TALLY_FULL : tally_ff + 2'd1;

   always_comb begin
      query_u_in = query_u_ff;
      query_v_in = query_v_ff;
      axis_in    = axis_ff;
      tally_in   = tally_ff;
      if (in_accept) begin
         if (is_start) begin
            query_u_in = u;
            query_v_in = v;
            axis_in    = new_axis;
            tally_in   = '0;
         end else begin
            tally_in = last ? 2'd0 : tally_inc;
         end
      end
   end

   // lane 0: previous vertex to this one; lane 1: closing edge back to the first
   always_comb begin
      pu[0] = prev_u_ff;
      pv[0] = prev_v_ff;
      cu[0] = u;
      cv[0] = v;
      pu[1] = u;
      pv[1] = v;
      cu[1] = first_u_ff;
      cv[1] = first_v_ff;
      edge_en[0] = !is_start && (tally_ff != 2'd0);
      edge_en[1] = !is_start && last && (tally_inc == TALLY_FULL);
      for (int i = 0; i < 2; i++) begin
         d1_in[i] = {pv[i][CW-1], pv[i]} - {cv[i][CW-1], cv[i]};
         a1_in[i] = {query_u_ff[CW-1], query_u_ff} - {cu[i][CW-1], cu[i]};
         b1_in[i] = {pu[i][CW-1], pu[i]} - {cu[i][CW-1], cu[i]};
         c1_in[i] = {query_v_ff[CW-1], query_v_ff} - {cv[i][CW-1], cv[i]};
         str1_in[i] = edge_en[i] && ((cv[i] > query_v_ff) != (pv[i] > query_v_ff));
      end
      ctrl1_in.start   = is_start;
      ctrl1_in.last    = last;
      ctrl1_in.too_few = is_start || (tally_inc != TALLY_FULL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_u_ff <= '0;
         query_v_ff <= '0;
         axis_ff    <= AXIS_X;
         tally_ff   <= '0;
      end else begin
         query_u_ff <= query_u_in;
         query_v_ff <= query_v_in;
         axis_ff    <= axis_in;
         tally_ff   <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept && !is_start) begin
         prev_u_ff <= u;
         prev_v_ff <= v;
         if (tally_ff == 2'd0) begin
            first_u_ff <= u;
            first_v_ff <= v;
         end
      end
      if (s1_load) begin
         ctrl1_ff <= ctrl1_in;
         a1_ff    <= a1_in;
         b1_ff    <= b1_in;
         c1_ff    <= c1_in;
         d1_ff    <= d1_in;
         str1_ff  <= str1_in;
      end
   end

endmodule

### sv/ppip_cross.sv
// One edge lane: registered cross products and the sign-aware crossing decision.
module ppip_cross import ppip_pkg::*; #(
   parameter int CW = 24
) (
   input  logic        clock,
   input  logic        load,
   input  logic [CW:0] a,
   input  logic [CW:0] b,
   input  logic [CW:0] c,
   input  logic [CW:0] d,
   input  logic        straddle,
   output logic        crosses
);

   localparam int PW = 2 * CW + 2;

   logic signed [PW-1:0] lhs_ff, rhs_ff, lhs_in, rhs_in;
   logic                 dpos_ff, str_ff;

   assign lhs_in = $signed(a) * $signed(d);
   assign rhs_in = $signed(b) * $signed(c);

   always_ff @(posedge clock) begin
      if (load) begin
         lhs_ff  <= lhs_in;
         rhs_ff  <= rhs_in;
         dpos_ff <= !d[CW] && (d != '0);
         str_ff  <= straddle;
      end
   end

   // point u strictly left of the edge's crossing u, flipped when dv is negative
   assign crosses = str_ff && (dpos_ff ? (lhs_ff < rhs_ff) : (rhs_ff < lhs_ff));

endmodule

### tb/testbench.sv
// Self-checking testbench for the projected point-in-polygon block: directed table plus random polygons.
`timescale 1ns / 100ps

module testbench;
   import ppip_pkg::*;

   localparam int COORD_W  = 24;
   localparam int REQ_W    = ((3*COORD_W+3*NORM_W+7)/8)*8;
   localparam int N_RANDOM = 1750;
   localparam int LIMIT    = 200000;
   localparam longint CMIN = -8388608;
   localparam longint CMAX = 8388607;

   typedef struct {
      opcode_type                  op;
      logic signed [COORD_W-1:0]   x, y, z;
      logic signed [NORM_W-1:0]    nx, ny, nz;
      logic                        last;
      bit                          has_exp;   // verdict typed into the table
      bit                          exp_in_poly;
      bit                          exp_few;
   } poly_item_type;

   typedef struct packed {
      logic too_few;
      logic in_poly;
   } verdict_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;  // coord_x, coord_y, coord_z, normal_x, normal_y, normal_z
   logic             req_tuser = 1'b0; // opcode
   logic             req_tlast = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;        // inside_res, too_few_vertices

   projected_point_in_polygon_top #(.COORD_WIDTH(COORD_W)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- crossing-number predictor ----------------
   longint      poly_qu = 0, poly_qv = 0;
   axis_type    poly_axis = AXIS_X;
   longint      first_u = 0, first_v = 0, prev_u = 0, prev_v = 0;
   bit          parity = 0;
   int          tally = 0;
   verdict_type verdict_q[$];
   int          errors = 0;
   int          cycles = 0;

   function automatic axis_type pick_axis(int nx, int ny, int nz);
      int ax, ay, az;
      ax = (nx < 0) ? -nx : nx;
      ay = (ny < 0) ? -ny : ny;
      az = (nz < 0) ? -nz : nz;
      if (ax >= ay && ax >= az) return AXIS_X;
      if (ay >= az) return AXIS_Y;
      return AXIS_Z;
   endfunction

   function automatic void project(axis_type a, longint x, longint y, longint z,
                                   output longint u, output longint v);
      case (a)
         AXIS_X: begin u = y; v = z; end
         AXIS_Y: begin u = x; v = z; end
         default: begin u = x; v = y; end
      endcase
   endfunction

   // ray from (qu,qv) toward +u; crossing counted when qu is strictly left of it
   function automatic bit edge_hits(longint qu, longint qv, longint pu, longint pv,
                                    longint cu, longint cv);
      longint d, lhs, rhs;
      if ((cv > qv) == (pv > qv)) return 1'b0;
      d   = pv - cv;
      lhs = (qu - cu) * d;
      rhs = (pu - cu) * (qv - cv);
      return (d > 0) ? (lhs < rhs) : (rhs < lhs);
   endfunction

   task automatic poly_step(input poly_item_type it, output bit fired,
                            output verdict_type v);
      longint u, w;
      fired = 1'b0;
      v     = '0;
      if (it.op == OP_START) begin
         poly_axis = pick_axis(it.nx, it.ny, it.nz);
         project(poly_axis, it.x, it.y, it.z, poly_qu, poly_qv);
         parity = 1'b0;
         tally  = 0;
      end else begin
         project(poly_axis, it.x, it.y, it.z, u, w);
         if (tally == 0) begin
            first_u = u;
            first_v = w;
         end else if (edge_hits(poly_qu, poly_qv, prev_u, prev_v, u, w)) begin
            parity ^= 1'b1;
         end
         prev_u = u;
         prev_v = w;
         if (tally < 3) tally++;
      end
      if (it.last) begin
         fired = 1'b1;
         if (tally >= 3) begin
            if (edge_hits(poly_qu, poly_qv, prev_u, prev_v, first_u, first_v))
               parity ^= 1'b1;
            v.in_poly = parity;
            v.too_few = 1'b0;
         end else begin
            v.in_poly = 1'b0;
            v.too_few = 1'b1;
         end
         parity = 1'b0;
         tally  = 0;
      end
   endtask

   // ---------------- stimulus construction ----------------
   poly_item_type stim_q[$];
   axis_type      gen_axis = AXIS_X;
   longint        gen_qu = 0, gen_qv = 0;

   function automatic poly_item_type mk(opcode_type op, longint x, longint y, longint z,
                                        int nx, int ny, int nz, bit last);
      poly_item_type it;
      it.op = op;
      it.x  = COORD_W'(x);
      it.y  = COORD_W'(y);
      it.z  = COORD_W'(z);
      it.nx = NORM_W'(nx);
      it.ny = NORM_W'(ny);
      it.nz = NORM_W'(nz);
      it.last = last;
      it.has_exp = 1'b0;
      it.exp_in_poly = 1'b0;
      it.exp_few = 1'b0;
      return it;
   endfunction

   function automatic poly_item_type typed(poly_item_type it, bit ins, bit few);
      it.has_exp     = 1'b1;
      it.exp_in_poly = ins;
      it.exp_few     = few;
      return it;
   endfunction

   task automatic add_item(input poly_item_type it);
      stim_q = {stim_q, it};
   endtask

   function automatic longint rand_coord();
      logic signed [COORD_W-1:0] t;
      t = COORD_W'($urandom);
      case ($urandom_range(0, 9))
         0: return CMIN;
         1: return CMAX;
         2, 3: return longint'(t);
         default: return longint'(int'($urandom_range(0, 40)) - 20);
      endcase
   endfunction

   function automatic int rand_norm();
      case ($urandom_range(0, 5))
         0: return -65536;
         1: return 65536;
         2: return 0;
         default: return int'($urandom_range(0, 131072)) - 65536;
      endcase
   endfunction

   function automatic int rand_sign(int m);
      return $urandom_range(0, 1) ? -m : m;
   endfunction

   task automatic gen_start(bit last);
      int nx, ny, nz, m;
      longint x, y, z;
      if ($urandom_range(0, 4) == 0) begin
         // equal magnitudes exercise the tie rules
         m  = $urandom_range(0, 65536);
         nx = rand_sign(m);
         ny = $urandom_range(0, 1) ? rand_sign(m) : rand_norm();
         nz = rand_sign(m);
      end else begin
         nx = rand_norm();
         ny = rand_norm();
         nz = rand_norm();
      end
      x = rand_coord();
      y = rand_coord();
      z = rand_coord();
      add_item(mk(OP_START, x, y, z, nx, ny, nz, last));
      gen_axis = pick_axis(nx, ny, nz);
      project(gen_axis, stim_q[$].x, stim_q[$].y, stim_q[$].z, gen_qu, gen_qv);
   endtask

   task automatic gen_vertex(longint u, longint v, bit last);
      longint other;
      other = rand_coord();
      case (gen_axis)
         AXIS_X:  add_item(mk(OP_VERTEX, other, u, v, rand_norm(), rand_norm(),
                              rand_norm(), last));
         AXIS_Y:  add_item(mk(OP_VERTEX, u, other, v, rand_norm(), rand_norm(),
                              rand_norm(), last));
         default: add_item(mk(OP_VERTEX, u, v, other, rand_norm(), rand_norm(),
                              rand_norm(), last));
      endcase
   endtask

   // polygon around the query point: ring walks directions in order, else scattered
   task automatic gen_polygon(bit close);
      int dir_u[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
      int dir_v[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
      longint pu[$], pv[$];
      int r, k, n, rot;
      if ($urandom_range(0, 1)) begin
         r   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4000000) : $urandom_range(1, 20);
         rot = $urandom_range(0, 7);
         for (k = 0; k < 8; k++) begin
            if ($urandom_range(0, 9) < 6) begin
               pu = {pu, gen_qu + dir_u[(k+rot)%8]*r + int'($urandom_range(0, 2)) - 1};
               pv = {pv, gen_qv + dir_v[(k+rot)%8]*r + int'($urandom_range(0, 2)) - 1};
            end
         end
      end else begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) begin
               pu = {pu, rand_coord()};
               pv = {pv, rand_coord()};
            end else begin
               pu = {pu, gen_qu + int'($urandom_range(0, 40)) - 20};
               pv = {pv, gen_qv + int'($urandom_range(0, 40)) - 20};
            end
         end
      end
      if (pu.size() == 0) begin
         pu = {pu, gen_qu};
         pv = {pv, gen_qv};
      end
      for (k = 0; k < pu.size(); k++)
         gen_vertex(pu[k], pv[k], close && (k == pu.size() - 1));
   endtask

   task automatic build_stimulus();
      int kind;
      // vertices before any start use the reset query (0,0) and drop X
      add_item(mk(OP_VERTEX, 0, -5, -5, 0, 0, 0, 1'b0));
      add_item(mk(OP_VERTEX, 0, 5, -5, 0, 0, 0, 1'b0));
      add_item(mk(OP_VERTEX, 0, 0, 5, 0, 0, 0, 1'b1));
      // empty polygon, one vertex, two vertices
      add_item(typed(mk(OP_START, 0, 0, 0, 0, 0, 0, 1'b1), 1'b0, 1'b1));
      add_item(typed(mk(OP_VERTEX, 1, 2, 3, 0, 0, 0, 1'b1), 1'b0, 1'b1));
      add_item(mk(OP_VERTEX, 4, 5, 6, 0, 0, 0, 1'b0));
      add_item(typed(mk(OP_VERTEX, 7, 8, 9, 0, 0, 0, 1'b1), 1'b0, 1'b1));
      // extreme coordinates, X/Y tie in the normal goes to X
      add_item(mk(OP_START, CMAX, CMIN, CMAX, -65536, 65536, 65536, 1'b0));
      add_item(mk(OP_VERTEX, CMIN, CMAX, CMIN, 65536, -1, -65536, 1'b0));
      add_item(mk(OP_VERTEX, CMAX, CMIN, CMIN, -65536, 65536, 7, 1'b0));
      add_item(mk(OP_VERTEX, 0, CMAX, CMAX, 1, 2, 3, 1'b1));
      // Y/Z tie goes to Y; square with horizontal edges
      add_item(mk(OP_START, 3, -3, 7, 0, 65536, -65536, 1'b0));
      add_item(mk(OP_VERTEX, 0, 11, 0, 0, 0, 0, 1'b0));
      add_item(mk(OP_VERTEX, 10, -11, 0, 0, 0, 0, 1'b0));
      add_item(mk(OP_VERTEX, 10, CMIN, 10, 0, 0, 0, 1'b0));
      add_item(mk(OP_VERTEX, 0, CMAX, 10, 0, 0, 0, 1'b1));
      // query kept after a result; a vertex level with the query point
      add_item(mk(OP_VERTEX, 0, 0, 7, 0, 0, 0, 1'b0));
      add_item(mk(OP_VERTEX, 10, 0, 2, 0, 0, 0, 1'b0));
      add_item(mk(OP_VERTEX, 10, 0, 12, 0, 0, 0, 1'b1));
      // Z dominant
      add_item(mk(OP_START, 1, 2, 3, 65535, -65535, -65536, 1'b0));
      add_item(mk(OP_VERTEX, 0, 0, CMIN, 0, 0, 0, 1'b0));
      add_item(mk(OP_VERTEX, 4, 0, CMAX, 0, 0, 0, 1'b0));
      add_item(mk(OP_VERTEX, 0, 4, 0, 0, 0, 0, 1'b1));
      gen_axis = AXIS_Z;
      gen_qu   = 1;
      gen_qv   = 2;

      while (stim_q.size() < N_RANDOM + 23) begin
         kind = $urandom_range(0, 19);
         if (kind < 10) begin
            gen_start(1'b0);
            gen_polygon(1'b1);
         end else if (kind < 14) begin
            gen_polygon(1'b1);
         end else if (kind < 16) begin
            gen_start(1'b1);
         end else if (kind < 18) begin
            // polygon abandoned by a fresh start
            gen_polygon(1'b0);
            gen_start(1'b0);
            gen_polygon(1'b1);
         end else if ($urandom_range(0, 1)) begin
            gen_start(1'($urandom_range(0, 1)));
         end else begin
            gen_vertex(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // ---------------- monitor: predict on input, check on output ----------------
   poly_item_type cur_item;

   always @(posedge clock) begin
      bit          fired;
      verdict_type pred, got, want;
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[1:0];
         if (verdict_q.size() == 0) begin
            $display("%0t: result with nothing expected: inside=%0b too_few=%0b",
                     $time, got.in_poly, got.too_few);
            errors++;
         end else begin
            want = verdict_q.pop_front();
            if (got.in_poly !== want.in_poly) begin
               $display("%0t: inside_res expected %0b actual %0b",
                        $time, want.in_poly, got.in_poly);
               errors++;
            end
            if (got.too_few !== want.too_few) begin
               $display("%0t: too_few_vertices expected %0b actual %0b",
                        $time, want.too_few, got.too_few);
               errors++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         poly_step(cur_item, fired, pred);
         if (fired) begin
            if (cur_item.has_exp) begin
               pred.in_poly = cur_item.exp_in_poly;
               pred.too_few = cur_item.exp_few;
            end
            verdict_q = {verdict_q, pred};
         end
      end
   end

   // ---------------- result side: random stalls plus one long hold-off ----------------
   initial begin
      int wait_n, taken;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         wait_n = ((taken / 16) % 4 == 1) ? 0 : $urandom_range(0, 3);
         if (wait_n > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
         if (taken == 40) begin
            // long hold-off so the pipe backs up into req
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end
      end
   end

   // ---------------- request side ----------------
   initial begin
      int gap, idx;
      build_stimulus();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (idx = 0; idx < stim_q.size(); idx++) begin
         gap = ((idx / 128) % 4 == 3) ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tdata  <= REQ_W'({stim_q[idx].nz, stim_q[idx].ny, stim_q[idx].nx,
                               stim_q[idx].z, stim_q[idx].y, stim_q[idx].x});
         req_tuser  <= stim_q[idx].op;
         req_tlast  <= stim_q[idx].last;
         cur_item   <= stim_q[idx];
         req_tvalid <= 1'b1;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### projected_point_in_polygon_top.f
sv/ppip_pkg.sv
sv/ppip_front.sv
sv/ppip_cross.sv
sv/projected_point_in_polygon_top.sv
tb/testbench.sv
